// File: rtl/core/pidbt_pkg.sv
// shared types and codes for the process id binding table
package pidbt_pkg;

  localparam int IdW = 22;

  localparam logic [2:0] ACT_BIND    = 3'd0;
  localparam logic [2:0] ACT_UNBIND  = 3'd1;
  localparam logic [2:0] ACT_QHOST   = 3'd2;
  localparam logic [2:0] ACT_QDEV    = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_BADPARAM = 3'd1;
  localparam logic [2:0] STS_BUSY     = 3'd2;
  localparam logic [2:0] STS_NOTFOUND = 3'd3;
  localparam logic [2:0] STS_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0]     act;
    logic           pass2;
    logic [IdW-1:0] host;
    logic [2:0]     slot;
    logic [IdW-1:0] dev;
  } cmd_t;

  typedef struct packed {
    logic           vld;
    logic           hit;
    logic           free_seen;
    logic [2:0]     sts;
    logic [IdW-1:0] f_host;
    logic [2:0]     f_slot;
    logic [IdW-1:0] f_dev;
  } tok_t;

endpackage

// File: rtl/core/process_id_binding_table.sv
// process id binding table top level: controller and a chain of entry cells
// a rejected word skips the walk; other words take a single walk through the chain,
// and a bind to an absent host takes a second walk to claim a free entry when the first saw one
// throughput: one word at a time, set by the token walking the cell chain one entry a cycle
// reset: slot bits and control clear at once, no clearing pass; host and device ids
// are not reset and are read only behind a set slot bit
module process_id_binding_table #(
  parameter int ENTRIES = 64,
  parameter int SLOTS   = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       action_i,
  input  logic [pidbt_pkg::IdW-1:0]        host_id_i,
  input  logic [2:0]                       slot_type_i,
  input  logic signed [pidbt_pkg::IdW:0]   device_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       status_o,
  output logic [pidbt_pkg::IdW-1:0]        found_host_id_o,
  output logic [2:0]                       found_slot_type_o,
  output logic [pidbt_pkg::IdW-1:0]        found_device_id_o
);
  import pidbt_pkg::*;

  cmd_t             cmd;
  tok_t             tok_w [ENTRIES+1];
  logic [ENTRIES:0] tok_vld;

  pidbt_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .host_id_i        (host_id_i),
    .slot_type_i      (slot_type_i),
    .device_id_i      (device_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_host_id_o  (found_host_id_o),
    .found_slot_type_o(found_slot_type_o),
    .found_device_id_o(found_device_id_o),
    .cmd_o            (cmd),
    .tok_o            (tok_w[0]),
    .tok_i            (tok_w[ENTRIES])
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pidbt_cell #(
      .SLOTS(SLOTS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .tok_i (tok_w[i]),
      .tok_o (tok_w[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
    assign tok_vld[i] = tok_w[i].vld;
  end

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one walk token in the chain");

  a_busy_while_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|tok_vld) |-> !in_ready_o)
    else $error("ready while a walk is in flight");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after taking a word");
`endif

endmodule

// File: rtl/core/pidbt_cell.sv
// one table entry: host key, slot bits and device ids, passes the walk token on
module pidbt_cell #(
  parameter int SLOTS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pidbt_pkg::cmd_t  cmd_i,
  input  pidbt_pkg::tok_t  tok_i,
  output pidbt_pkg::tok_t  tok_o
);
  import pidbt_pkg::*;

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] held_q, held_d;
  logic [IdW-1:0]   host_q;
  logic [IdW-1:0]   dev_q [SLOTS];
  logic             host_we;
  logic             dev_we;
  logic [SlotW-1:0] slot_idx;
  logic [SLOTS-1:0] match;
  logic             any_match;
  logic [2:0]       first_slot;
  logic             host_hit;
  tok_t             tok_d, tok_q;

  assign slot_idx = cmd_i.slot[SlotW-1:0];
  assign host_hit = (|held_q) && (host_q == cmd_i.host);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = held_q[s] && (dev_q[s] == cmd_i.dev);
    end
  end

  assign any_match = |match;

  // lowest matching slot
  always_comb begin
    first_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        first_slot = 3'(s);
      end
    end
  end

  always_comb begin
    tok_d   = tok_i;
    held_d  = held_q;
    host_we = 1'b0;
    dev_we  = 1'b0;
    if (tok_i.vld) begin
      case (cmd_i.act)
        ACT_BIND: begin
          if (!cmd_i.pass2) begin
            if (held_q == '0) begin
              tok_d.free_seen = 1'b1;
            end
            if (host_hit) begin
              tok_d.hit = 1'b1;
              if (held_q[slot_idx]) begin
                tok_d.sts = STS_BUSY;
              end else begin
                tok_d.sts        = STS_OK;
                held_d[slot_idx] = 1'b1;
                dev_we           = 1'b1;
              end
            end
          end else if (!tok_i.hit && (held_q == '0)) begin
            // claim the first free entry
            tok_d.hit        = 1'b1;
            tok_d.sts        = STS_OK;
            held_d[slot_idx] = 1'b1;
            host_we          = 1'b1;
            dev_we           = 1'b1;
          end
        end
        ACT_UNBIND: begin
          if (host_hit) begin
            tok_d.hit = 1'b1;
            if (held_q[slot_idx] && (dev_q[slot_idx] == cmd_i.dev)) begin
              tok_d.sts        = STS_OK;
              held_d[slot_idx] = 1'b0;
            end else begin
              tok_d.sts = STS_BUSY;
            end
          end
        end
        ACT_QHOST: begin
          if (host_hit) begin
            tok_d.hit = 1'b1;
            if (held_q[slot_idx]) begin
              tok_d.sts   = STS_OK;
              tok_d.f_dev = dev_q[slot_idx];
            end else begin
              tok_d.sts = STS_NOTFOUND;
            end
          end
        end
        ACT_QDEV: begin
          if (!tok_i.hit && any_match) begin
            tok_d.hit    = 1'b1;
            tok_d.sts    = STS_OK;
            tok_d.f_host = host_q;
            tok_d.f_slot = first_slot;
          end
        end
        ACT_RELEASE: begin
          held_d = held_q & ~match;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      tok_q  <= '0;
    end else begin
      held_q <= held_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (host_we) begin
      host_q <= cmd_i.host;
    end
    if (dev_we) begin
      dev_q[slot_idx] <= cmd_i.dev;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/pidbt_ctrl.sv
// request checks, walk sequencing and output register
module pidbt_ctrl #(
  parameter int SLOTS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               action_i,
  input  logic [pidbt_pkg::IdW-1:0] host_id_i,
  input  logic [2:0]               slot_type_i,
  input  logic signed [pidbt_pkg::IdW:0] device_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic [pidbt_pkg::IdW-1:0] found_host_id_o,
  output logic [2:0]               found_slot_type_o,
  output logic [pidbt_pkg::IdW-1:0] found_device_id_o,
  output pidbt_pkg::cmd_t          cmd_o,
  output pidbt_pkg::tok_t          tok_o,
  input  pidbt_pkg::tok_t          tok_i
);
  import pidbt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [3:0] SlotLimit = 4'(SLOTS);

  logic [1:0]     state_q, state_d;
  logic           inject_q, inject_d;
  logic           out_valid_q, out_valid_d;
  cmd_t           cmd_q, cmd_d;
  logic [2:0]     res_sts_q, res_sts_d;
  logic [IdW-1:0] res_host_q, res_host_d;
  logic [2:0]     res_slot_q, res_slot_d;
  logic [IdW-1:0] res_dev_q, res_dev_d;
  logic [2:0]     sts_q;
  logic [IdW-1:0] f_host_q;
  logic [2:0]     f_slot_q;
  logic [IdW-1:0] f_dev_q;
  logic           accept;
  logic           bad;
  logic           load_out;
  logic [2:0]     miss_sts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign bad = (action_i > ACT_RELEASE) ||
               ((action_i <= ACT_QHOST) && ({1'b0, slot_type_i} >= SlotLimit)) ||
               ((action_i != ACT_QHOST) && device_id_i[IdW]);

  assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (cmd_q.act)
      ACT_BIND:    miss_sts = STS_FULL;
      ACT_RELEASE: miss_sts = STS_OK;
      default:     miss_sts = STS_NOTFOUND;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    inject_d    = 1'b0;
    cmd_d       = cmd_q;
    res_sts_d   = res_sts_q;
    res_host_d  = res_host_q;
    res_slot_d  = res_slot_q;
    res_dev_d   = res_dev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d.act   = action_i;
          cmd_d.pass2 = 1'b0;
          cmd_d.host  = host_id_i;
          cmd_d.slot  = slot_type_i;
          cmd_d.dev   = device_id_i[IdW-1:0];
          if (bad) begin
            res_sts_d  = STS_BADPARAM;
            res_host_d = '0;
            res_slot_d = '0;
            res_dev_d  = '0;
            state_d    = ST_FIN;
          end else begin
            inject_d = 1'b1;
            state_d  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (tok_i.vld) begin
          if ((cmd_q.act == ACT_BIND) && !cmd_q.pass2 && !tok_i.hit && tok_i.free_seen) begin
            // host absent: second walk claims the lowest free entry
            cmd_d.pass2 = 1'b1;
            inject_d    = 1'b1;
          end else begin
            res_sts_d  = tok_i.hit ? tok_i.sts : miss_sts;
            res_host_d = tok_i.f_host;
            res_slot_d = tok_i.f_slot;
            res_dev_d  = tok_i.f_dev;
            state_d    = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inject_q    <= inject_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_sts_q  <= res_sts_d;
    res_host_q <= res_host_d;
    res_slot_q <= res_slot_d;
    res_dev_q  <= res_dev_d;
    if (load_out) begin
      sts_q    <= res_sts_q;
      f_host_q <= res_host_q;
      f_slot_q <= res_slot_q;
      f_dev_q  <= res_dev_q;
    end
  end

  always_comb begin
    tok_o     = '0;
    tok_o.vld = inject_q;
  end

  assign cmd_o             = cmd_q;
  assign out_valid_o       = out_valid_q;
  assign status_o          = sts_q;
  assign found_host_id_o   = f_host_q;
  assign found_slot_type_o = f_slot_q;
  assign found_device_id_o = f_dev_q;

endmodule

// File: test/process_id_binding_table_checker.sv
// checker for the process id binding table: predicts each result and compares it
`timescale 1ns / 100ps

module process_id_binding_table_checker #(
  parameter int ENTRIES = 64,
  parameter int SLOTS   = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [2:0]                    action_i,
  input  logic [pidbt_pkg::IdW-1:0]     host_id_i,
  input  logic [2:0]                    slot_type_i,
  input  logic [pidbt_pkg::IdW:0]       device_id_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [2:0]                    status_i,
  input  logic [pidbt_pkg::IdW-1:0]     found_host_id_i,
  input  logic [2:0]                    found_slot_type_i,
  input  logic [pidbt_pkg::IdW-1:0]     found_device_id_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import pidbt_pkg::*;

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] host;
    logic [2:0]     slot;
    logic [IdW-1:0] dev;
  } binding_result_t;

  logic                 entry_used  [ENTRIES];
  logic [IdW-1:0]       entry_host  [ENTRIES];
  logic [SLOTS-1:0]     slot_held   [ENTRIES];
  logic [IdW-1:0]       slot_device [ENTRIES][SLOTS];

  binding_result_t binding_results_q[$];
  binding_result_t want;
  int              mismatches;

  assign fail_count_o = mismatches;

  function automatic binding_result_t predict_binding(input logic [2:0] act,
                                                      input logic [IdW-1:0] host,
                                                      input logic [2:0] slot,
                                                      input logic [IdW:0] dev_word);
    binding_result_t r;
    logic [IdW-1:0]  dev;
    int              e;
    int              s;
    int              hit;
    r   = '0;
    dev = dev_word[IdW-1:0];
    hit = -1;
    for (e = 0; e < ENTRIES; e++)
      if (hit < 0 && entry_used[e] && entry_host[e] == host) hit = e;
    if (act > ACT_RELEASE) begin
      r.status = STS_BADPARAM;
    end else if (act <= ACT_QHOST && slot >= SLOTS) begin
      r.status = STS_BADPARAM;
    end else if (act != ACT_QHOST && dev_word[IdW]) begin
      r.status = STS_BADPARAM;
    end else begin
      case (act)
        ACT_BIND: begin
          if (hit < 0) begin
            for (e = 0; e < ENTRIES; e++)
              if (hit < 0 && !entry_used[e]) hit = e;
            if (hit < 0) begin
              r.status = STS_FULL;
            end else begin
              entry_used[hit]        = 1'b1;
              entry_host[hit]        = host;
              slot_held[hit]         = '0;
              slot_held[hit][slot]   = 1'b1;
              slot_device[hit][slot] = dev;
            end
          end else if (slot_held[hit][slot]) begin
            r.status = STS_BUSY;
          end else begin
            slot_held[hit][slot]   = 1'b1;
            slot_device[hit][slot] = dev;
          end
        end
        ACT_UNBIND: begin
          if (hit < 0) begin
            r.status = STS_NOTFOUND;
          end else if (!slot_held[hit][slot] || slot_device[hit][slot] != dev) begin
            r.status = STS_BUSY;
          end else begin
            slot_held[hit][slot] = 1'b0;
            if (slot_held[hit] == '0) entry_used[hit] = 1'b0;
          end
        end
        ACT_QHOST: begin
          if (hit < 0 || !slot_held[hit][slot]) r.status = STS_NOTFOUND;
          else r.dev = slot_device[hit][slot];
        end
        ACT_QDEV: begin
          r.status = STS_NOTFOUND;
          for (e = 0; e < ENTRIES; e++)
            for (s = 0; s < SLOTS; s++)
              if (r.status == STS_NOTFOUND && entry_used[e] && slot_held[e][s] &&
                  slot_device[e][s] == dev) begin
                r.status = STS_OK;
                r.host   = entry_host[e];
                r.slot   = 3'(s);
              end
        end
        default: begin
          for (e = 0; e < ENTRIES; e++)
            if (entry_used[e]) begin
              for (s = 0; s < SLOTS; s++)
                if (slot_held[e][s] && slot_device[e][s] == dev) slot_held[e][s] = 1'b0;
              if (slot_held[e] == '0) entry_used[e] = 1'b0;
            end
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (entry_used[e]) begin
        entry_used[e] = 1'b0;
        entry_host[e] = '0;
        slot_held[e]  = '0;
      end
      foreach (slot_device[e, s]) slot_device[e][s] = '0;
      binding_results_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (binding_results_q.size() == 0) begin
          $display("%0t: result word with no request waiting, expected none, actual status %0d",
                   $time, status_i);
          mismatches++;
        end else begin
          want = binding_results_q.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("found_host_id", 32'(want.host), 32'(found_host_id_i));
          check_field("found_slot_type", 32'(want.slot), 32'(found_slot_type_i));
          check_field("found_device_id", 32'(want.dev), 32'(found_device_id_i));
        end
      end
      if (in_valid_i && in_ready_i)
        binding_results_q.push_back(predict_binding(action_i, host_id_i, slot_type_i,
                                                    device_id_i));
      pending_o <= binding_results_q.size();
    end
  end

endmodule

// File: test/process_id_binding_table_tb.sv
// testbench top for the process id binding table: stimulus, idling and verdict
`timescale 1ns / 100ps

module process_id_binding_table_tb;
  import pidbt_pkg::*;

  localparam int ENTRIES        = 64;
  localparam int SLOTS          = 4;
  localparam int HOST_POOL      = 12;
  localparam int DEV_POOL       = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  localparam logic [IdW-1:0]    HOST_MAX = '1;
  localparam logic signed [IdW:0] DEV_MAX  = {1'b0, {IdW{1'b1}}};
  localparam logic signed [IdW:0] DEV_NONE = '1;
  localparam logic signed [IdW:0] DEV_MIN  = {1'b1, {IdW{1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            action = ACT_BIND;
  logic [IdW-1:0]        host_id = '0;
  logic [2:0]            slot_type = '0;
  logic signed [IdW:0]   device_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            status;
  logic [IdW-1:0]        found_host_id;
  logic [2:0]            found_slot_type;
  logic [IdW-1:0]        found_device_id;

  int                    pending;
  int                    fail_count;
  int                    idle_cycles = 0;
  int                    ready_run = 0;
  logic                  calm = 1'b0;

  logic [IdW-1:0]        host_pool [HOST_POOL];
  logic [IdW-1:0]        dev_pool  [DEV_POOL];

  always #4 clk = ~clk;

  process_id_binding_table #(
    .ENTRIES (ENTRIES),
    .SLOTS   (SLOTS)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .action_i          (action),
    .host_id_i         (host_id),
    .slot_type_i       (slot_type),
    .device_id_i       (device_id),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .found_host_id_o   (found_host_id),
    .found_slot_type_o (found_slot_type),
    .found_device_id_o (found_device_id)
  );

  process_id_binding_table_checker #(
    .ENTRIES (ENTRIES),
    .SLOTS   (SLOTS)
  ) checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .action_i          (action),
    .host_id_i         (host_id),
    .slot_type_i       (slot_type),
    .device_id_i       (device_id),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .status_i          (status),
    .found_host_id_i   (found_host_id),
    .found_slot_type_i (found_slot_type),
    .found_device_id_i (found_device_id),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // mostly short gaps, a few long ones, none while calm
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 6);
      ready_run <= draw_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("process_id_binding_table_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [2:0] act, input logic [IdW-1:0] host,
                           input logic [2:0] slot, input logic signed [IdW:0] dev);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    host_id   <= host;
    slot_type <= slot;
    device_id <= dev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic refill_pools();
    foreach (host_pool[i]) host_pool[i] = IdW'($urandom());
    foreach (dev_pool[i]) dev_pool[i] = IdW'($urandom());
    host_pool[0] = $urandom_range(0, 1) ? HOST_MAX : '0;
    dev_pool[0]  = $urandom_range(0, 1) ? DEV_MAX[IdW-1:0] : '0;
  endtask

  task automatic send_random();
    logic [2:0]          act;
    logic [IdW-1:0]      host;
    logic [2:0]          slot;
    logic signed [IdW:0] dev;
    int                  r;
    r = $urandom_range(0, 99);
    if (r < 30) act = ACT_BIND;
    else if (r < 48) act = ACT_UNBIND;
    else if (r < 63) act = ACT_QHOST;
    else if (r < 80) act = ACT_QDEV;
    else if (r < 95) act = ACT_RELEASE;
    else act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    host = ($urandom_range(0, 9) < 8) ? host_pool[$urandom_range(0, HOST_POOL - 1)]
                                      : IdW'($urandom());
    slot = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, SLOTS - 1))
                                      : 3'($urandom_range(SLOTS, 7));
    r = $urandom_range(0, 99);
    if (r < 85) dev = {1'b0, dev_pool[$urandom_range(0, DEV_POOL - 1)]};
    else if (r < 90) dev = DEV_NONE;
    else dev = (IdW+1)'($urandom());
    send_word(act, host, slot, dev);
  endtask

  // more hosts than entries, then clear the pool devices out again
  task automatic fill_table();
    logic [IdW-1:0] base;
    base = IdW'($urandom());
    for (int i = 0; i < ENTRIES + 2; i++)
      send_word(ACT_BIND, base + IdW'(i), 3'($urandom_range(0, SLOTS - 1)),
                {1'b0, dev_pool[$urandom_range(0, DEV_POOL - 1)]});
    foreach (dev_pool[i])
      send_word(ACT_RELEASE, IdW'($urandom()), 3'($urandom()), {1'b0, dev_pool[i]});
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ACT_QDEV, '0, 3'd0, '0);
    send_word(ACT_BIND, '0, 3'd0, '0);
    send_word(ACT_BIND, HOST_MAX, 3'd3, DEV_MAX);
    send_word(ACT_BIND, '0, 3'd0, 23'sd5);
    send_word(ACT_BIND, '0, 3'd0, '0);
    send_word(ACT_BIND, '0, 3'd1, DEV_MAX);
    send_word(ACT_QHOST, '0, 3'd0, DEV_NONE);
    send_word(ACT_QHOST, HOST_MAX, 3'd1, '0);
    send_word(ACT_QHOST, 22'd12345, 3'd0, '0);
    send_word(ACT_QHOST, '0, 3'(SLOTS), '0);
    send_word(ACT_QDEV, '0, 3'd7, DEV_MAX);
    send_word(ACT_BIND, '0, 3'd7, DEV_NONE);
    send_word(ACT_BIND, '0, 3'd2, DEV_MIN);
    send_word(ACT_UNBIND, 22'd777, 3'd0, '0);
    send_word(ACT_UNBIND, '0, 3'd0, 23'sd7);
    send_word(ACT_UNBIND, HOST_MAX, 3'd2, 23'sd1);
    send_word(ACT_UNBIND, '0, 3'd0, '0);
    for (logic [3:0] a = {1'b0, ACT_UNUSED_FIRST}; a <= {1'b0, ACT_UNUSED_LAST}; a++)
      send_word(a[2:0], HOST_MAX, 3'd7, DEV_NONE);
    send_word(ACT_RELEASE, '0, 3'd0, DEV_NONE);
    send_word(ACT_RELEASE, '0, 3'd7, DEV_MAX);
    send_word(ACT_RELEASE, '0, 3'd0, 23'sd99);
    send_word(ACT_QDEV, '0, 3'd0, DEV_MAX);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      refill_pools();
      calm <= (phase == 3);
      for (int i = 0; i < 250; i++) begin
        send_random();
        if (i % 100 == 99) drain_results();
      end
      if (phase == 1 || phase == 4) fill_table();
      drain_results();
    end

    calm <= 1'b0;
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("process_id_binding_table_tb passed");
    end else begin
      $display("process_id_binding_table_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pidbt_pkg.sv
rtl/core/pidbt_cell.sv
rtl/core/pidbt_ctrl.sv
rtl/core/process_id_binding_table.sv
test/process_id_binding_table_checker.sv
test/process_id_binding_table_tb.sv
